// ===== sv/ordered_list_engine_macros.svh =====
// assertion macros used by the checker file of the ordered list engine
// clocked on clk_i, disabled while rst_ni is low
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered list engine check failed");

// next-cycle implication
`define OLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");

`endif

// ===== sv/ole_pkg.sv =====
// types and codes of the ordered list engine
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ole_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 9;   // holds any position or length up to 256

  typedef enum logic [2:0] {
    FUNC_SEARCH    = 3'd0,
    FUNC_INS_FRONT = 3'd1,
    FUNC_INS_END   = 3'd2,
    FUNC_DEL_FRONT = 3'd3,
    FUNC_DEL_END   = 3'd4,
    FUNC_INS_AT    = 3'd5,
    FUNC_DEL_AT    = 3'd6,
    FUNC_UPDATE_AT = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADIDX = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_WRITE  = 2'd3
  } cell_op_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    cell_op_e           op;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/ole_cell.sv =====
// one storage cell of the ordered list row
// depends on ole_pkg for the command struct
`timescale 1ns / 1ps

module ole_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                        clk_i,
  input  ole_pkg::cell_cmd_t          cmd_i,
  input  logic [ole_pkg::VALUE_W-1:0] left_i,
  input  logic [ole_pkg::VALUE_W-1:0] right_i,
  output logic [ole_pkg::VALUE_W-1:0] data_o,
  output logic                        match_o
);

  logic [ole_pkg::VALUE_W-1:0] data_q, data_d;
  logic [ole_pkg::POS_W-1:0]   my_pos;

  assign my_pos = ole_pkg::POS_W'(IDX);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      ole_pkg::OP_INSERT: begin
        if (my_pos > cmd_i.pos) begin
          data_d = left_i;
        end else if (my_pos == cmd_i.pos) begin
          data_d = cmd_i.value;
        end
      end
      ole_pkg::OP_DELETE: begin
        if (my_pos >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      ole_pkg::OP_WRITE: begin
        if (my_pos == cmd_i.pos) begin
          data_d = cmd_i.value;
        end
      end
      ole_pkg::OP_HOLD: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // only held entries take part in a search
  assign match_o = (data_q == cmd_i.value) && (my_pos < cmd_i.len);
  assign data_o  = data_q;

endmodule

// ===== sv/ole_ctrl.sv =====
// request decode and length register of the ordered list engine
// depends on ole_pkg for codes and the cell command struct
`timescale 1ns / 1ps

module ole_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [2:0]                  func_i,
  input  logic [7:0]                  index_i,
  input  logic [ole_pkg::VALUE_W-1:0] value_i,
  output ole_pkg::cell_cmd_t          cmd_o,
  output ole_pkg::status_e            status_o,
  output logic                        search_o,
  output logic [ole_pkg::POS_W-1:0]   count_o
);

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

  logic [LEN_W-1:0]          len_q, len_d;
  logic [ole_pkg::POS_W-1:0] len9, idx9, pos;
  logic                      full, empty, idx_ok;
  ole_pkg::cell_op_e         op;

  assign len9   = ole_pkg::POS_W'(len_q);
  assign idx9   = ole_pkg::POS_W'(index_i);
  assign full   = (len9 == ole_pkg::POS_W'(CAPACITY));
  assign empty  = (len_q == '0);
  assign idx_ok = (idx9 < len9);

  always_comb begin
    op       = ole_pkg::OP_HOLD;
    pos      = '0;
    status_o = ole_pkg::ST_OK;
    unique case (ole_pkg::func_e'(func_i))
      ole_pkg::FUNC_SEARCH: begin
        op = ole_pkg::OP_HOLD;
      end
      ole_pkg::FUNC_INS_FRONT: begin
        if (full) status_o = ole_pkg::ST_FULL;
        else op = ole_pkg::OP_INSERT;
      end
      ole_pkg::FUNC_INS_END: begin
        pos = len9;
        if (full) status_o = ole_pkg::ST_FULL;
        else op = ole_pkg::OP_INSERT;
      end
      ole_pkg::FUNC_INS_AT: begin
        // an index past the end appends
        pos = idx_ok ? idx9 : len9;
        if (full) status_o = ole_pkg::ST_FULL;
        else op = ole_pkg::OP_INSERT;
      end
      ole_pkg::FUNC_DEL_FRONT: begin
        if (empty) status_o = ole_pkg::ST_EMPTY;
        else op = ole_pkg::OP_DELETE;
      end
      ole_pkg::FUNC_DEL_END: begin
        pos = len9 - ole_pkg::POS_W'(1);
        if (empty) status_o = ole_pkg::ST_EMPTY;
        else op = ole_pkg::OP_DELETE;
      end
      ole_pkg::FUNC_DEL_AT: begin
        pos = idx9;
        if (empty) status_o = ole_pkg::ST_EMPTY;
        else if (!idx_ok) status_o = ole_pkg::ST_BADIDX;
        else op = ole_pkg::OP_DELETE;
      end
      ole_pkg::FUNC_UPDATE_AT: begin
        pos = idx9;
        if (!idx_ok) status_o = ole_pkg::ST_BADIDX;
        else op = ole_pkg::OP_WRITE;
      end
    endcase
  end

  always_comb begin
    len_d = len_q;
    if (op == ole_pkg::OP_INSERT) begin
      len_d = len_q + LEN_W'(1);
    end else if (op == ole_pkg::OP_DELETE) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (accept_i) begin
      len_q <= len_d;
    end
  end

  assign cmd_o.op    = accept_i ? op : ole_pkg::OP_HOLD;
  assign cmd_o.pos   = pos;
  assign cmd_o.len   = len9;
  assign cmd_o.value = value_i;
  assign search_o    = (ole_pkg::func_e'(func_i) == ole_pkg::FUNC_SEARCH);
  assign count_o     = ole_pkg::POS_W'(len_d);

endmodule

// ===== sv/ordered_list_engine.sv =====
// ordered list engine top level: decode, row of cells, result pipeline
// depends on ole_pkg, ole_ctrl and ole_cell
`timescale 1ns / 1ps

// usage
//   input channel: in_valid_i with func_i, index_i, value_i; in_stall_o
//   pushes back. a transaction is taken on a rising edge with valid high
//   and stall low. output channel: out_valid_o with status_o, found_o,
//   count_o; the receiver holds out_stall_i high to keep the result.
//   every request gives exactly one result, in request order.
// timing
//   the row of CAPACITY cells shifts, writes or compares all entries in
//   the edge that takes the request, so one request a cycle is taken
//   while in_stall_o is low. after acceptance the middle stage holds the
//   per-cell match bits, then the output register holds the or-reduced
//   found flag with status and count.
// reset
//   rst_ni clears the entry count and both result stages; cell contents
//   are left as they are and are never read before written.
// stall
//   a stalled result stays on the outputs; the middle stage still takes
//   one more request, then in_stall_o rises until the output drains.

module ordered_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  func_i,
  input  logic [7:0]                  index_i,
  input  logic signed [31:0]          value_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        found_o,
  output logic [8:0]                  count_o
);

  ole_pkg::cell_cmd_t          cmd;
  ole_pkg::status_e            req_status;
  logic                        req_search;
  logic [ole_pkg::POS_W-1:0]   req_count;
  logic                        accept;

  // row of cells, front entry in cell 0
  logic [ole_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]         cell_match;

  // middle stage: match bits waiting for reduction
  logic                        a_valid_q, a_valid_d;
  logic [CAPACITY-1:0]         a_match_q;
  ole_pkg::status_e            a_status_q;
  logic [ole_pkg::POS_W-1:0]   a_count_q;
  logic                        a_load, b_load;

  // output stage
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  status_q;
  logic                        found_q;
  logic [8:0]                  count_q;

  assign accept = in_valid_i && !in_stall_o;

  ole_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (func_i),
    .index_i  (index_i),
    .value_i  (value_i),
    .cmd_o    (cmd),
    .status_o (req_status),
    .search_o (req_search),
    .count_o  (req_count)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ole_pkg::VALUE_W-1:0] left_data, right_data;

    // the front cell never shifts from its left; the last never from its right
    if (k == 0) begin : g_front
      assign left_data = cmd.value;
    end else begin : g_inner_l
      assign left_data = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_back
      assign right_data = cell_data[k];
    end else begin : g_inner_r
      assign right_data = cell_data[k+1];
    end

    ole_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[k]),
      .match_o (cell_match[k])
    );
  end

  // pipeline control: out_stall_i reaches in_stall_o combinationally through b_load
  assign b_load      = a_valid_q && (!out_valid_q || !out_stall_i);
  assign a_load      = accept;
  assign in_stall_o  = a_valid_q && !b_load;
  assign a_valid_d   = a_load || (a_valid_q && !b_load);
  assign out_valid_d = b_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // match bits only count for a search
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_match_q  <= req_search ? cell_match : '0;
      a_status_q <= req_status;
      a_count_q  <= req_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      status_q <= a_status_q;
      found_q  <= |a_match_q;
      count_q  <= a_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign count_o     = count_q;

endmodule

// ===== sv/ole_checker.sv =====
// port-level checks of the ordered list engine, bound to the top level
// depends on ole_pkg and ordered_list_engine_macros.svh
`timescale 1ns / 1ps
`include "ordered_list_engine_macros.svh"

module ole_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       found_o,
  input logic [8:0] count_o
);

  // a stalled result transaction holds
  `OLE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(status_o) && $stable(count_o) && $stable(found_o))

  `OLE_ASSERT_NOW(a_count_cap, out_valid_o, count_o <= 9'(CAPACITY))

  `OLE_ASSERT_NOW(a_found_ok, out_valid_o && found_o, status_o == ole_pkg::ST_OK)

  `OLE_ASSERT_NOW(a_full_count, out_valid_o && status_o == ole_pkg::ST_FULL,
                  count_o == 9'(CAPACITY))

  `OLE_ASSERT_NOW(a_empty_count, out_valid_o && status_o == ole_pkg::ST_EMPTY,
                  count_o == 9'd0)

endmodule

bind ordered_list_engine ole_checker #(
  .CAPACITY (CAPACITY)
) u_ole_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .found_o     (found_o),
  .count_o     (count_o)
);

// ===== dv/tb_ordered_list_engine.sv =====
// self-checking testbench of the ordered list engine: directed and random requests
// depends on ole_pkg and ordered_list_engine; a shadow list predicts every result
`timescale 1ns / 1ps

module tb_ordered_list_engine;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned LEN_W        = $clog2(CAPACITY + 1);
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // one request as driven on the input channel
  typedef struct packed {
    ole_pkg::func_e     func;
    logic [7:0]         index;
    logic signed [31:0] value;
  } request_t;

  // one result as seen on the output channel
  typedef struct packed {
    ole_pkg::status_e status;
    logic             found;
    logic [8:0]       count;
  } outcome_t;

  // shadow of the held entries, front first
  typedef struct packed {
    logic [CAPACITY-1:0][31:0] ent;
    logic [LEN_W-1:0]          len;
  } list_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [2:0]         func_i      = 3'd0;
  logic [7:0]         index_i     = 8'd0;
  logic signed [31:0] value_i     = 32'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic               found_o;
  logic [8:0]         count_o;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  list_t       held_list;      // state as the block holds it, advanced on acceptance
  list_t       plan_list;      // state as foreseen while the stimulus is built
  int unsigned failures    = 0;
  int unsigned cycle_count = 0;

  ordered_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .found_o    (found_o),
    .count_o    (count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // list arithmetic
  // ---------------------------------------------------------------------------

  // insert shifts the tail back by one; a position past the end appends
  function automatic ole_pkg::status_e insert_entry(inout list_t st,
                                                    input int unsigned pos,
                                                    input logic [31:0] v);
    int unsigned k;
    if (st.len >= CAPACITY) return ole_pkg::ST_FULL;
    if (pos > st.len) pos = st.len;
    for (k = st.len; k > pos; k--) st.ent[k] = st.ent[k-1];
    st.ent[pos] = v;
    st.len      = st.len + 1'b1;
    return ole_pkg::ST_OK;
  endfunction

  // delete closes the gap by pulling the tail forward
  function automatic ole_pkg::status_e remove_entry(inout list_t st,
                                                    input int unsigned pos);
    int unsigned k;
    if (st.len == 0) return ole_pkg::ST_EMPTY;
    if (pos >= st.len) return ole_pkg::ST_BADIDX;
    for (k = pos; k + 1 < st.len; k++) st.ent[k] = st.ent[k+1];
    st.len = st.len - 1'b1;
    return ole_pkg::ST_OK;
  endfunction

  // carries one request through the list and gives its status, found flag and count
  function automatic void apply_request(inout list_t st, input request_t rq,
                                        output outcome_t rs);
    int unsigned k;
    rs.status = ole_pkg::ST_OK;
    rs.found  = 1'b0;
    case (rq.func)
      ole_pkg::FUNC_SEARCH: begin
        for (k = 0; k < st.len; k++)
          if (st.ent[k] == rq.value) rs.found = 1'b1;
      end
      ole_pkg::FUNC_INS_FRONT: rs.status = insert_entry(st, 0, rq.value);
      ole_pkg::FUNC_INS_END:   rs.status = insert_entry(st, st.len, rq.value);
      ole_pkg::FUNC_DEL_FRONT: rs.status = remove_entry(st, 0);
      ole_pkg::FUNC_DEL_END:
        rs.status = remove_entry(st, (st.len == 0) ? 0 : st.len - 1);
      ole_pkg::FUNC_INS_AT:    rs.status = insert_entry(st, rq.index, rq.value);
      ole_pkg::FUNC_DEL_AT:    rs.status = remove_entry(st, rq.index);
      default: begin
        if (rq.index < st.len) st.ent[rq.index] = rq.value;
        else rs.status = ole_pkg::ST_BADIDX;
      end
    endcase
    rs.count = 9'(st.len);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_request(input ole_pkg::func_e f, input logic [7:0] idx,
                             input logic [31:0] v);
    request_t rq;
    outcome_t unused;
    rq.func  = f;
    rq.index = idx;
    rq.value = v;
    apply_request(plan_list, rq, unused);
    pending_requests.push_back(rq);
  endtask

  // values favor entries already held so searches hit and updates collide
  function automatic logic [31:0] pick_value(input list_t st);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return (st.len > 0) ? st.ent[$urandom_range(st.len - 1)] : $urandom;
      4: return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // indexes mostly land inside the list or right at its end
  function automatic logic [7:0] pick_index(input list_t st);
    int unsigned r;
    r = $urandom_range(19);
    if (r < 13) return 8'($urandom_range(st.len));
    else if (r < 17) return 8'(st.len + $urandom_range(3));
    else return 8'($urandom_range(255));
  endfunction

  // fill mode drives the list to full, drain mode to empty, mixed wanders
  function automatic ole_pkg::func_e pick_func(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(99);
    if (mode == 2) return ole_pkg::func_e'($urandom_range(7));
    if (r < 25) return $urandom_range(1) ? ole_pkg::FUNC_SEARCH : ole_pkg::FUNC_UPDATE_AT;
    if ((mode == 0) == (r < 85)) begin
      case ($urandom_range(2))
        0: return ole_pkg::FUNC_INS_FRONT;
        1: return ole_pkg::FUNC_INS_END;
        default: return ole_pkg::FUNC_INS_AT;
      endcase
    end
    case ($urandom_range(2))
      0: return ole_pkg::FUNC_DEL_FRONT;
      1: return ole_pkg::FUNC_DEL_END;
      default: return ole_pkg::FUNC_DEL_AT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of transactions with random gaps in between
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  request_t    next_req;
  request_t    taken_req;
  outcome_t    taken_outcome;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // transaction accepted at this edge: advance the shadow list
      if (in_valid_i && !in_stall_o) begin
        taken_req.func  = ole_pkg::func_e'(func_i);
        taken_req.index = index_i;
        taken_req.value = value_i;
        apply_request(held_list, taken_req, taken_outcome);
        expected_outcomes.push_back(taken_outcome);
      end
      // a stalled payload stays put; otherwise load the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= next_req.func;
          index_i    <= next_req.index;
          value_i    <= next_req.value;
          if (burst_left == 0) begin
            if ($urandom_range(7) == 0) begin
              burst_left = $urandom_range(300, 100);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(30, 1);
              gap_left   = $urandom_range(6);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every accepted result and drives the receiver stall
  // ---------------------------------------------------------------------------

  int unsigned stall_mode  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_phase = 0;
  logic        stall_next;
  outcome_t    oldest;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with no request waiting: status %0d found %0d count %0d",
               status_o, found_o, count_o);
        failures++;
      end else begin
        oldest = expected_outcomes.pop_front();
        if (status_o !== oldest.status) begin
          $error("status mismatch: expected %0d, actual %0d", oldest.status, status_o);
          failures++;
        end
        if (found_o !== oldest.found) begin
          $error("found mismatch: expected %0d, actual %0d", oldest.found, found_o);
          failures++;
        end
        if (count_o !== oldest.count) begin
          $error("count mismatch: expected %0d, actual %0d", oldest.count, count_o);
          failures++;
        end
      end
    end

    // stall pattern: none, light random, heavy random or periodic
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(200, 20);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(9) < 3);
      2:       stall_next = ($urandom_range(9) < 7);
      default: stall_next = ((stall_phase % 5) < 2);
    endcase
    out_stall_i <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: build stimulus, reset, wait for all requests and results to drain out
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned n;
    list_t       cleared;

    cleared   = '0;
    held_list = cleared;
    plan_list = cleared;

    // empty list corner cases
    add_request(ole_pkg::FUNC_SEARCH,    8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_FRONT, 8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_END,   8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_AT,    8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_UPDATE_AT, 8'd0,   32'h1234_5678);
    // insert at a far index appends, even on an empty list
    add_request(ole_pkg::FUNC_INS_AT,    8'd255, 32'h7fff_ffff);
    add_request(ole_pkg::FUNC_INS_FRONT, 8'd0,   32'h8000_0000);
    add_request(ole_pkg::FUNC_INS_END,   8'd0,   32'hffff_ffff);
    add_request(ole_pkg::FUNC_INS_AT,    8'd1,   32'h0000_0000);
    add_request(ole_pkg::FUNC_SEARCH,    8'd0,   32'h8000_0000);
    add_request(ole_pkg::FUNC_SEARCH,    8'd0,   32'h0000_3039);
    add_request(ole_pkg::FUNC_SEARCH,    8'd0,   32'hffff_ffff);
    // update and delete just past the end are refused, those inside the list go through
    add_request(ole_pkg::FUNC_UPDATE_AT, 8'd4,   32'h5555_5555);
    add_request(ole_pkg::FUNC_UPDATE_AT, 8'd3,   32'haaaa_aaaa);
    add_request(ole_pkg::FUNC_UPDATE_AT, 8'd0,   32'h0000_0005);
    add_request(ole_pkg::FUNC_DEL_AT,    8'd4,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_AT,    8'd255, 32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_AT,    8'd1,   32'h0000_0000);
    add_request(ole_pkg::FUNC_SEARCH,    8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_END,   8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_FRONT, 8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_DEL_FRONT, 8'd0,   32'h0000_0000);
    add_request(ole_pkg::FUNC_INS_AT,    8'd170, 32'h0f0f_0f0f);

    // random part, shaped so the list swings between full and empty
    mode      = 0;
    mode_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(60, 15);
      end else begin
        mode_left--;
      end
      add_request(pick_func(mode), pick_index(plan_list), pick_value(plan_list));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
